@@ design/amint_pkg.sv @@
// ----------------------------------------------------------------------------
// amint_pkg
// Types and constants shared by the agent motion integrator pipeline.
// ----------------------------------------------------------------------------
package amint_pkg;

    // fixed point layout
    localparam int HEAD_FRAC = 14;
    localparam int TIME_FRAC = 16;
    localparam int VEL_W     = 35;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int LANES     = 2;

    // configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 2'd1;

    localparam logic [31:0] FORCE_LIMIT_RESET = 32'd65536;
    localparam logic [31:0] SPEED_LIMIT_RESET = 32'd655360;

    // heading saturation magnitudes
    localparam logic [15:0] HEAD_POS_MAX = 16'h7fff;
    localparam logic [15:0] HEAD_NEG_MAX = 16'h8000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        speed_now;
        logic signed [15:0] head_x;
        logic signed [15:0] head_y;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
        logic [15:0]        time_step;
    } agent_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic [31:0]        new_speed;
        logic signed [15:0] new_head_x;
        logic signed [15:0] new_head_y;
        logic               halted;
    } result_t;

endpackage

@@ design/agent_motion_integrator_top.sv @@
// ----------------------------------------------------------------------------
// agent_motion_integrator_top
// One fixed-point Euler step for a flocking agent: force limiting, velocity
// update, speed and heading recovery, speed clamp and saturating move.
// ----------------------------------------------------------------------------
// The block accepts one agent request every clock cycle while nothing stalls
// and carries each from the input register to the result register. The
// pipeline holds two pipelined square roots (16 stages each, two root bits
// per stage), the force-limit divider (16 stages, two quotient bits per
// stage) and the heading divider (8 stages). A stall on the result side
// freezes the whole pipeline without losing or repeating a request.
// force_limit and speed_limit may only be written while no request is in
// flight; writes to an unused index are ignored.
module agent_motion_integrator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                agent_valid,
    output logic                                agent_stall,
    input  amint_pkg::agent_t                   agent,
    output logic                                result_valid,
    input  logic                                result_stall,
    output amint_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [amint_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                         cfg_data
);
    import amint_pkg::*;

    typedef struct packed {
        agent_t                   item;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic [31:0]              dun_x;
        logic [31:0]              dun_y;
        logic                     limited;
    } div1_side_t;

    typedef struct packed {
        div1_side_t  side;
        logic [63:0] num_x;
        logic [63:0] num_y;
        logic [31:0] fmag;
    } s4_t;

    typedef struct packed {
        agent_t                   item;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic [31:0]              dvm_x;
        logic [31:0]              dvm_y;
    } s5_t;

    typedef struct packed {
        agent_t                   item;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
    } s6_t;

    typedef struct packed {
        agent_t                   item;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic                     big;
        logic [30:0]              mxs_x;
        logic [30:0]              mxs_y;
    } s7_t;

    typedef struct packed {
        agent_t                   item;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic                     big;
    } sq2_side_t;

    typedef struct packed {
        sq2_side_t   side;
        logic [61:0] sq_x;
        logic [61:0] sq_y;
    } s8_t;

    typedef struct packed {
        sq2_side_t   side;
        logic [63:0] sum;
    } s9_t;

    typedef struct packed {
        agent_t           item;
        logic             neg_x;
        logic             neg_y;
        logic [VEL_W-1:0] spd;
        logic             zero;
        logic             ovf_x;
        logic             ovf_y;
    } div2_side_t;

    typedef struct packed {
        div2_side_t  side;
        logic [47:0] num_x;
        logic [47:0] num_y;
    } s10_t;

    typedef struct packed {
        agent_t             item;
        logic [31:0]        speed_sel;
        logic signed [15:0] head_x;
        logic signed [15:0] head_y;
        logic [31:0]        new_speed;
        logic               halted;
    } s11_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        travel;
        logic signed [15:0] head_x;
        logic signed [15:0] head_y;
        logic [31:0]        new_speed;
        logic               halted;
    } s12_t;

    typedef struct packed {
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [VEL_W-1:0] dx;
        logic signed [VEL_W-1:0] dy;
        logic signed [15:0]      head_x;
        logic signed [15:0]      head_y;
        logic [31:0]             new_speed;
        logic                    halted;
    } s13_t;

    // magnitude helpers; mag32 and mag16 are exact for the most negative code
    function automatic logic [31:0] mag32(input logic [31:0] a);
        logic [31:0] t;
        t = a[31] ? (~a + 32'd1) : a;
        return t;
    endfunction

    function automatic logic [15:0] mag16(input logic [15:0] a);
        logic [15:0] t;
        t = a[15] ? (~a + 16'd1) : a;
        return t;
    endfunction

    function automatic logic [VEL_W-2:0] mag_vel(input logic [VEL_W-1:0] v);
        logic [VEL_W-1:0] t;
        t = v[VEL_W-1] ? (~v + 1'b1) : v;
        return t[VEL_W-2:0];
    endfunction

    function automatic logic [VEL_W-1:0] apply_sign(input logic neg,
                                                    input logic [VEL_W-2:0] m);
        logic [VEL_W-1:0] e;
        e = {1'b0, m};
        return neg ? (~e + 1'b1) : e;
    endfunction

    function automatic logic [31:0] move_sat(input logic [31:0] p,
                                             input logic [VEL_W-1:0] d);
        logic [35:0] s;
        s = {{4{p[31]}}, p} + {{(36-VEL_W){d[VEL_W-1]}}, d};
        if (s[35:31] == 5'b00000 || s[35:31] == 5'b11111)
        begin
            return s[31:0];
        end
        return s[35] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    logic        en;
    logic [31:0] force_limit_reg;
    logic [31:0] speed_limit_reg;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic        s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic        s9_valid_reg, s10_valid_reg, s11_valid_reg, s12_valid_reg;
    logic        s13_valid_reg, result_valid_reg;

    agent_t      s1_reg;
    agent_t      s2_item_reg;
    logic [63:0] s2_fx2_reg, s2_fy2_reg;
    agent_t      s3_item_reg;
    logic [63:0] s3_fsum_reg;
    s4_t         s4_reg, s4_next;
    s5_t         s5_reg, s5_next;
    s6_t         s6_reg, s6_next;
    s7_t         s7_reg, s7_next;
    s8_t         s8_reg;
    s9_t         s9_reg;
    s10_t        s10_reg, s10_next;
    s11_t        s11_reg, s11_next;
    s12_t        s12_reg, s12_next;
    s13_t        s13_reg, s13_next;
    result_t     result_reg, result_next;

    logic        fm_valid;
    logic [31:0] fm_root;
    agent_t      fm_item;

    logic                          d1_valid;
    logic [LANES-1:0][31:0]        d1_hi, d1_lo, d1_quo;
    div1_side_t                    d1_side;

    logic        vm_valid;
    logic [31:0] vm_root;
    sq2_side_t   vm_side;

    logic                          d2_valid;
    logic [LANES-1:0][VEL_W-1:0]   d2_hi;
    logic [LANES-1:0][15:0]        d2_lo, d2_quo;
    div2_side_t                    d2_side;

    // whole pipeline moves unless the result register is held
    assign en           = !(result_valid_reg && result_stall);
    assign agent_stall  = !en;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_limit_reg <= FORCE_LIMIT_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FORCE_LIMIT: force_limit_reg <= cfg_data;
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            s6_valid_reg     <= 1'b0;
            s7_valid_reg     <= 1'b0;
            s8_valid_reg     <= 1'b0;
            s9_valid_reg     <= 1'b0;
            s10_valid_reg    <= 1'b0;
            s11_valid_reg    <= 1'b0;
            s12_valid_reg    <= 1'b0;
            s13_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg     <= agent_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= fm_valid;
            s5_valid_reg     <= d1_valid;
            s6_valid_reg     <= s5_valid_reg;
            s7_valid_reg     <= s6_valid_reg;
            s8_valid_reg     <= s7_valid_reg;
            s9_valid_reg     <= s8_valid_reg;
            s10_valid_reg    <= vm_valid;
            s11_valid_reg    <= d2_valid;
            s12_valid_reg    <= s11_valid_reg;
            s13_valid_reg    <= s12_valid_reg;
            result_valid_reg <= s13_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg      <= agent;
            s2_item_reg <= s1_reg;
            s2_fx2_reg  <= mag32(s1_reg.push_x) * mag32(s1_reg.push_x);
            s2_fy2_reg  <= mag32(s1_reg.push_y) * mag32(s1_reg.push_y);
            s3_item_reg <= s2_item_reg;
            s3_fsum_reg <= s2_fx2_reg + s2_fy2_reg;
            s4_reg      <= s4_next;
            s5_reg      <= s5_next;
            s6_reg      <= s6_next;
            s7_reg      <= s7_next;
            s8_reg.side <= {s7_reg.item, s7_reg.vel_x, s7_reg.vel_y, s7_reg.big};
            s8_reg.sq_x <= s7_reg.mxs_x * s7_reg.mxs_x;
            s8_reg.sq_y <= s7_reg.mxs_y * s7_reg.mxs_y;
            s9_reg.side <= s8_reg.side;
            s9_reg.sum  <= {2'b00, s8_reg.sq_x} + {2'b00, s8_reg.sq_y};
            s10_reg     <= s10_next;
            s11_reg     <= s11_next;
            s12_reg     <= s12_next;
            s13_reg     <= s13_next;
            result_reg  <= result_next;
        end
    end

    // force magnitude
    amint_sqrt #(
        .SIDE_W ($bits(agent_t)),
        .STEPS  (2)
    ) u_force_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .radicand  (s3_fsum_reg),
        .in_side   (s3_item_reg),
        .out_valid (fm_valid),
        .root      (fm_root),
        .out_side  (fm_item)
    );

    // old velocity, force products and limit decision
    always_comb
    begin
        logic [47:0] pvx, pvy, pdx, pdy;
        pvx = mag16(fm_item.head_x) * fm_item.speed_now;
        pvy = mag16(fm_item.head_y) * fm_item.speed_now;
        pdx = mag32(fm_item.push_x) * fm_item.time_step;
        pdy = mag32(fm_item.push_y) * fm_item.time_step;
        s4_next.side.item    = fm_item;
        s4_next.side.vel_x   = apply_sign(fm_item.head_x[15], pvx[46:HEAD_FRAC]);
        s4_next.side.vel_y   = apply_sign(fm_item.head_y[15], pvy[46:HEAD_FRAC]);
        s4_next.side.dun_x   = pdx[47:TIME_FRAC];
        s4_next.side.dun_y   = pdy[47:TIME_FRAC];
        s4_next.side.limited = fm_root > force_limit_reg;
        s4_next.num_x        = mag32(fm_item.push_x) * force_limit_reg;
        s4_next.num_y        = mag32(fm_item.push_y) * force_limit_reg;
        s4_next.fmag         = fm_root;
    end

    // limited force components, |f| * limit / |F|
    assign d1_hi[0] = s4_reg.num_x[63:32];
    assign d1_hi[1] = s4_reg.num_y[63:32];
    assign d1_lo[0] = s4_reg.num_x[31:0];
    assign d1_lo[1] = s4_reg.num_y[31:0];

    amint_div #(
        .D_W    (32),
        .Q_W    (32),
        .SIDE_W ($bits(div1_side_t)),
        .STEPS  (2)
    ) u_force_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .rem_hi    (d1_hi),
        .dvd_lo    (d1_lo),
        .divisor   (s4_reg.fmag),
        .in_side   (s4_reg.side),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .out_side  (d1_side)
    );

    // velocity change over the time step
    always_comb
    begin
        logic [47:0] pax, pay;
        pax = d1_quo[0] * d1_side.item.time_step;
        pay = d1_quo[1] * d1_side.item.time_step;
        s5_next.item  = d1_side.item;
        s5_next.vel_x = d1_side.vel_x;
        s5_next.vel_y = d1_side.vel_y;
        s5_next.dvm_x = d1_side.limited ? pax[47:TIME_FRAC] : d1_side.dun_x;
        s5_next.dvm_y = d1_side.limited ? pay[47:TIME_FRAC] : d1_side.dun_y;
    end

    // new velocity
    always_comb
    begin
        s6_next.item  = s5_reg.item;
        s6_next.vel_x = s5_reg.vel_x
                      + apply_sign(s5_reg.item.push_x[31], {2'b00, s5_reg.dvm_x});
        s6_next.vel_y = s5_reg.vel_y
                      + apply_sign(s5_reg.item.push_y[31], {2'b00, s5_reg.dvm_y});
    end

    // velocity magnitudes, pre-scaled by eight when large
    always_comb
    begin
        logic [VEL_W-2:0] mx, my;
        mx = mag_vel(s6_reg.vel_x);
        my = mag_vel(s6_reg.vel_y);
        s7_next.item  = s6_reg.item;
        s7_next.vel_x = s6_reg.vel_x;
        s7_next.vel_y = s6_reg.vel_y;
        s7_next.big   = (|mx[VEL_W-2:31]) || (|my[VEL_W-2:31]);
        s7_next.mxs_x = s7_next.big ? mx[33:3] : mx[30:0];
        s7_next.mxs_y = s7_next.big ? my[33:3] : my[30:0];
    end

    // speed from velocity
    amint_sqrt #(
        .SIDE_W ($bits(sq2_side_t)),
        .STEPS  (2)
    ) u_speed_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_valid_reg),
        .radicand  (s9_reg.sum),
        .in_side   (s9_reg.side),
        .out_valid (vm_valid),
        .root      (vm_root),
        .out_side  (vm_side)
    );

    // rescale speed, heading dividends and quotient overflow
    always_comb
    begin
        logic [VEL_W-1:0] s;
        logic [47:0]      nx, ny;
        s  = vm_side.big ? {vm_root, 3'b000} : {3'b000, vm_root};
        nx = {mag_vel(vm_side.vel_x), 14'd0};
        ny = {mag_vel(vm_side.vel_y), 14'd0};
        s10_next.side.item  = vm_side.item;
        s10_next.side.neg_x = vm_side.vel_x[VEL_W-1];
        s10_next.side.neg_y = vm_side.vel_y[VEL_W-1];
        s10_next.side.spd   = s;
        s10_next.side.zero  = (s == '0);
        s10_next.side.ovf_x = {3'b000, nx} >= {s, 16'd0};
        s10_next.side.ovf_y = {3'b000, ny} >= {s, 16'd0};
        s10_next.num_x      = nx;
        s10_next.num_y      = ny;
    end

    // heading components, v * 2^14 / speed
    assign d2_hi[0] = {3'b000, s10_reg.num_x[47:16]};
    assign d2_hi[1] = {3'b000, s10_reg.num_y[47:16]};
    assign d2_lo[0] = s10_reg.num_x[15:0];
    assign d2_lo[1] = s10_reg.num_y[15:0];

    amint_div #(
        .D_W    (VEL_W),
        .Q_W    (16),
        .SIDE_W ($bits(div2_side_t)),
        .STEPS  (2)
    ) u_head_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s10_valid_reg),
        .rem_hi    (d2_hi),
        .dvd_lo    (d2_lo),
        .divisor   (s10_reg.side.spd),
        .in_side   (s10_reg.side),
        .out_valid (d2_valid),
        .quotient  (d2_quo),
        .out_side  (d2_side)
    );

    // heading saturation, speed clamp and case selection
    always_comb
    begin
        logic [15:0] hmx, hmy;
        logic [31:0] sc;
        logic        no_force;
        if (d2_side.neg_x)
        begin
            hmx = (d2_side.ovf_x || d2_quo[0] > HEAD_NEG_MAX) ? HEAD_NEG_MAX : d2_quo[0];
            hmx = ~hmx + 16'd1;
        end
        else
        begin
            hmx = (d2_side.ovf_x || d2_quo[0] > HEAD_POS_MAX) ? HEAD_POS_MAX : d2_quo[0];
        end
        if (d2_side.neg_y)
        begin
            hmy = (d2_side.ovf_y || d2_quo[1] > HEAD_NEG_MAX) ? HEAD_NEG_MAX : d2_quo[1];
            hmy = ~hmy + 16'd1;
        end
        else
        begin
            hmy = (d2_side.ovf_y || d2_quo[1] > HEAD_POS_MAX) ? HEAD_POS_MAX : d2_quo[1];
        end
        sc = (d2_side.spd > {3'b000, speed_limit_reg}) ? speed_limit_reg
                                                      : d2_side.spd[31:0];
        no_force = (d2_side.item.push_x == '0) && (d2_side.item.push_y == '0);

        s11_next.item = d2_side.item;
        if (no_force)
        begin
            // coasting along the old heading
            s11_next.speed_sel = d2_side.item.speed_now;
            s11_next.head_x    = d2_side.item.head_x;
            s11_next.head_y    = d2_side.item.head_y;
            s11_next.new_speed = d2_side.item.speed_now;
            s11_next.halted    = 1'b0;
        end
        else if (d2_side.zero)
        begin
            // velocity cancelled out
            s11_next.speed_sel = '0;
            s11_next.head_x    = d2_side.item.head_x;
            s11_next.head_y    = d2_side.item.head_y;
            s11_next.new_speed = '0;
            s11_next.halted    = 1'b1;
        end
        else
        begin
            s11_next.speed_sel = sc;
            s11_next.head_x    = hmx;
            s11_next.head_y    = hmy;
            s11_next.new_speed = sc;
            s11_next.halted    = 1'b0;
        end
    end

    // distance travelled
    always_comb
    begin
        logic [47:0] pd;
        pd = s11_reg.speed_sel * s11_reg.item.time_step;
        s12_next.pos_x     = s11_reg.item.pos_x;
        s12_next.pos_y     = s11_reg.item.pos_y;
        s12_next.travel    = pd[47:TIME_FRAC];
        s12_next.head_x    = s11_reg.head_x;
        s12_next.head_y    = s11_reg.head_y;
        s12_next.new_speed = s11_reg.new_speed;
        s12_next.halted    = s11_reg.halted;
    end

    // displacement along the heading
    always_comb
    begin
        logic [47:0] px, py;
        px = mag16(s12_reg.head_x) * s12_reg.travel;
        py = mag16(s12_reg.head_y) * s12_reg.travel;
        s13_next.pos_x     = s12_reg.pos_x;
        s13_next.pos_y     = s12_reg.pos_y;
        s13_next.dx        = apply_sign(s12_reg.head_x[15], px[46:HEAD_FRAC]);
        s13_next.dy        = apply_sign(s12_reg.head_y[15], py[46:HEAD_FRAC]);
        s13_next.head_x    = s12_reg.head_x;
        s13_next.head_y    = s12_reg.head_y;
        s13_next.new_speed = s12_reg.new_speed;
        s13_next.halted    = s12_reg.halted;
    end

    // saturating position update
    always_comb
    begin
        result_next.new_pos_x  = s13_reg.halted ? s13_reg.pos_x
                                                : move_sat(s13_reg.pos_x, s13_reg.dx);
        result_next.new_pos_y  = s13_reg.halted ? s13_reg.pos_y
                                                : move_sat(s13_reg.pos_y, s13_reg.dy);
        result_next.new_speed  = s13_reg.new_speed;
        result_next.new_head_x = s13_reg.head_x;
        result_next.new_head_y = s13_reg.head_y;
        result_next.halted     = s13_reg.halted;
    end

endmodule

@@ design/amint_sqrt.sv @@
// ----------------------------------------------------------------------------
// amint_sqrt
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit radicand,
// a fixed number of digit-recurrence steps per stage, sideband carried along.
// ----------------------------------------------------------------------------
module amint_sqrt #(
    parameter int SIDE_W = 1,
    parameter int STEPS  = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [amint_pkg::RAD_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [amint_pkg::ROOT_W-1:0]  root,
    output logic [SIDE_W-1:0]             out_side
);
    import amint_pkg::*;

    localparam int STAGES = ROOT_W / STEPS;

    logic [RAD_W-1:0]  rem_reg   [STAGES];
    logic [RAD_W-1:0]  res_reg   [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];
    logic [STAGES-1:0] valid_reg;

    logic [RAD_W-1:0]  rem_next  [STAGES];
    logic [RAD_W-1:0]  res_next  [STAGES];

    logic [RAD_W-1:0]  rem_w     [STAGES+1];
    logic [RAD_W-1:0]  res_w     [STAGES+1];
    logic [SIDE_W-1:0] side_w    [STAGES+1];

    assign rem_w[0]  = radicand;
    assign res_w[0]  = '0;
    assign side_w[0] = in_side;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            assign rem_w[k+1]  = rem_reg[k];
            assign res_w[k+1]  = res_reg[k];
            assign side_w[k+1] = side_reg[k];

            // a few recurrence steps, one result bit each
            always_comb
            begin
                logic [RAD_W-1:0] x;
                logic [RAD_W-1:0] r;
                logic [RAD_W-1:0] b;
                x = rem_w[k];
                r = res_w[k];
                for (int j = 0; j < STEPS; j++)
                begin
                    b = RAD_W'(1) << (2 * (ROOT_W - 1 - (k * STEPS + j)));
                    if (x >= r + b)
                    begin
                        x = x - (r + b);
                        r = (r >> 1) + b;
                    end
                    else
                    begin
                        r = r >> 1;
                    end
                end
                rem_next[k] = x;
                res_next[k] = r;
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next[k];
                    res_reg[k]  <= res_next[k];
                    side_reg[k] <= side_w[k];
                end
            end
        end
    endgenerate

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = res_w[STAGES][ROOT_W-1:0];
    assign out_side  = side_w[STAGES];

endmodule

@@ design/amint_div.sv @@
// ----------------------------------------------------------------------------
// amint_div
// Pipelined two-lane restoring divider sharing one divisor. The upper part
// of each dividend must be below the divisor; quotients are Q_W bits wide.
// ----------------------------------------------------------------------------
module amint_div #(
    parameter int D_W    = 32,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1,
    parameter int STEPS  = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [amint_pkg::LANES-1:0][D_W-1:0]  rem_hi,
    input  logic [amint_pkg::LANES-1:0][Q_W-1:0]  dvd_lo,
    input  logic [D_W-1:0]                        divisor,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic [amint_pkg::LANES-1:0][Q_W-1:0]  quotient,
    output logic [SIDE_W-1:0]                     out_side
);
    import amint_pkg::*;

    localparam int STAGES = Q_W / STEPS;

    logic [LANES-1:0][D_W-1:0] rem_reg  [STAGES];
    logic [LANES-1:0][Q_W-1:0] quo_reg  [STAGES];
    logic [D_W-1:0]            dvs_reg  [STAGES];
    logic [SIDE_W-1:0]         side_reg [STAGES];
    logic [STAGES-1:0]         valid_reg;

    logic [LANES-1:0][D_W-1:0] rem_next [STAGES];
    logic [LANES-1:0][Q_W-1:0] quo_next [STAGES];

    logic [LANES-1:0][D_W-1:0] rem_w    [STAGES+1];
    logic [LANES-1:0][Q_W-1:0] quo_w    [STAGES+1];
    logic [D_W-1:0]            dvs_w    [STAGES+1];
    logic [SIDE_W-1:0]         side_w   [STAGES+1];

    assign rem_w[0]  = rem_hi;
    assign quo_w[0]  = dvd_lo;
    assign dvs_w[0]  = divisor;
    assign side_w[0] = in_side;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            assign rem_w[k+1]  = rem_reg[k];
            assign quo_w[k+1]  = quo_reg[k];
            assign dvs_w[k+1]  = dvs_reg[k];
            assign side_w[k+1] = side_reg[k];

            // shift in dividend bits, subtract where it fits
            always_comb
            begin
                logic [D_W:0]   t;
                logic [D_W-1:0] r;
                logic [Q_W-1:0] q;
                rem_next[k] = rem_w[k];
                quo_next[k] = quo_w[k];
                for (int l = 0; l < LANES; l++)
                begin
                    r = rem_w[k][l];
                    q = quo_w[k][l];
                    for (int j = 0; j < STEPS; j++)
                    begin
                        t = {r, q[Q_W-1]};
                        q = q << 1;
                        if (t >= {1'b0, dvs_w[k]})
                        begin
                            t    = t - {1'b0, dvs_w[k]};
                            q[0] = 1'b1;
                        end
                        r = t[D_W-1:0];
                    end
                    rem_next[k][l] = r;
                    quo_next[k][l] = q;
                end
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next[k];
                    quo_reg[k]  <= quo_next[k];
                    dvs_reg[k]  <= dvs_w[k];
                    side_reg[k] <= side_w[k];
                end
            end
        end
    endgenerate

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = quo_w[STAGES];
    assign out_side  = side_w[STAGES];

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for agent_motion_integrator_top: directed corner
// requests, register changes and random traffic under idle and stall phases,
// each result compared field by field with an in-bench integrator model.
// ----------------------------------------------------------------------------
module tb_top;
    import amint_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int PIPE_DRAIN = 100;
    localparam int QUIET_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic agent_valid = 1'b0;
    logic agent_stall;
    agent_t agent = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    longint unsigned force_lim = FORCE_LIMIT_RESET;
    longint unsigned speed_lim = SPEED_LIMIT_RESET;
    result_t pending_steps[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    bit failed = 1'b0;

    agent_motion_integrator_top dut (.*);

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // integrator model
    // ------------------------------------------------------------------------
    function automatic longint unsigned magn(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint signed_as(longint sgn, longint unsigned m);
        return sgn < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint trunc_mul(longint a, longint unsigned b, int sh);
        return signed_as(a, (magn(a) * b) >> sh);
    endfunction

    function automatic longint unsigned root(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint heading_of(longint v, longint unsigned s);
        longint unsigned q = (magn(v) << HEAD_FRAC) / s;
        if (v < 0)
        begin
            if (q > 32768) q = 32768;
            return -longint'(q);
        end
        if (q > 32767) q = 32767;
        return q;
    endfunction

    function automatic result_t integrate(agent_t a);
        result_t r;
        longint px = a.pos_x, py = a.pos_y;
        longint hx = a.head_x, hy = a.head_y;
        longint fx = a.push_x, fy = a.push_y;
        longint unsigned spd = a.speed_now, dt = a.time_step;
        longint unsigned fmag, mx, my, s, travel, ax, ay;
        longint vx, vy, nhx = hx, nhy = hy, nx = px, ny = py;
        longint unsigned nspd = spd;
        int sh;
        bit stop = 1'b0;
        fmag = root(magn(fx) * magn(fx) + magn(fy) * magn(fy));
        if (fmag == 0)
        begin
            // coasting along the current heading
            travel = (spd * dt) >> TIME_FRAC;
            nx = clip32(px + trunc_mul(hx, travel, HEAD_FRAC));
            ny = clip32(py + trunc_mul(hy, travel, HEAD_FRAC));
        end
        else
        begin
            vx = trunc_mul(hx, spd, HEAD_FRAC);
            vy = trunc_mul(hy, spd, HEAD_FRAC);
            if (fmag > force_lim)
            begin
                ax = magn(fx) * force_lim / fmag;
                ay = magn(fy) * force_lim / fmag;
                vx += signed_as(fx, (ax * dt) >> TIME_FRAC);
                vy += signed_as(fy, (ay * dt) >> TIME_FRAC);
            end
            else
            begin
                vx += trunc_mul(fx, dt, TIME_FRAC);
                vy += trunc_mul(fy, dt, TIME_FRAC);
            end
            mx = magn(vx);
            my = magn(vy);
            sh = (mx >= 64'h8000_0000 || my >= 64'h8000_0000) ? 3 : 0;
            mx >>= sh;
            my >>= sh;
            s = root(mx * mx + my * my) << sh;
            if (s == 0)
            begin
                stop = 1'b1;
                nspd = 0;
            end
            else
            begin
                nhx = heading_of(vx, s);
                nhy = heading_of(vy, s);
                if (s > speed_lim) s = speed_lim;
                nspd = s;
                travel = (s * dt) >> TIME_FRAC;
                nx = clip32(px + trunc_mul(nhx, travel, HEAD_FRAC));
                ny = clip32(py + trunc_mul(nhy, travel, HEAD_FRAC));
            end
        end
        r.new_pos_x = nx[31:0];
        r.new_pos_y = ny[31:0];
        r.new_speed = nspd[31:0];
        r.new_head_x = nhx[15:0];
        r.new_head_y = nhy[15:0];
        r.halted = stop;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request capture, result checking, watchdog
    // ------------------------------------------------------------------------
    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (agent_valid && !agent_stall)
                pending_steps.push_back(integrate(agent));
            if (result_valid && !result_stall)
            begin
                if (pending_steps.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, result);
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_steps.pop_front();
                    check_field("new_pos_x", want.new_pos_x, result.new_pos_x);
                    check_field("new_pos_y", want.new_pos_y, result.new_pos_y);
                    check_field("new_speed", want.new_speed, result.new_speed);
                    check_field("new_head_x", want.new_head_x, result.new_head_x);
                    check_field("new_head_y", want.new_head_y, result.new_head_y);
                    check_field("halted", want.halted, result.halted);
                end
            end
            if ((agent_valid && !agent_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("agent_motion_integrator_top verification failed");
                $finish;
            end
        end
    end

    // result side stall, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_agent(agent_t a);
        while ($urandom_range(99) < idle_pct)
        begin
            agent_valid <= 1'b0;
            @(posedge clk);
        end
        agent <= a;
        agent_valid <= 1'b1;
        do @(posedge clk); while (agent_stall);
    endtask

    task automatic wait_idle();
        agent_valid <= 1'b0;
        @(posedge clk);
        while (pending_steps.size() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FORCE_LIMIT) force_lim = val;
        else if (idx == REG_SPEED_LIMIT) speed_lim = val;
    endtask

    task automatic set_limits(logic [31:0] f, logic [31:0] s);
        wait_idle();
        write_reg(REG_FORCE_LIMIT, f);
        write_reg(REG_SPEED_LIMIT, s);
    endtask

    // ------------------------------------------------------------------------
    // random request generation
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick32();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h00ff_ffff);
            2: v = $urandom_range(0, 4096);
            3: v = $urandom_range(0, 32'h07ff_ffff);
            default:
                case ($urandom_range(3))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'hffff_ffff;
                    default: v = 32'h0000_0001;
                endcase
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    function automatic agent_t random_agent();
        agent_t a;
        int hx;
        longint unsigned hy;
        a.pos_x = pick32();
        a.pos_y = pick32();
        a.speed_now = pick32();
        a.time_step = $urandom_range(3) == 0 ? 16'hffff : 16'($urandom);
        if ($urandom_range(4) != 0)
        begin
            // proper unit heading
            hx = $urandom_range(0, 16384);
            hy = root(longint'(16384 * 16384) - longint'(hx * hx));
            a.head_x = $urandom_range(1) ? -16'(hx) : 16'(hx);
            a.head_y = $urandom_range(1) ? -16'(hy) : 16'(hy);
        end
        else
        begin
            a.head_x = 16'($urandom);
            a.head_y = 16'($urandom);
        end
        case ($urandom_range(9))
            0, 1:
            begin
                a.push_x = '0;
                a.push_y = '0;
            end
            2:
            begin
                // no motion left: halts
                a.speed_now = '0;
                a.time_step = '0;
                a.push_x = pick32();
                a.push_y = pick32() | 32'd1;
            end
            default:
            begin
                a.push_x = pick32();
                a.push_y = pick32();
            end
        endcase
        return a;
    endfunction

    task automatic run_random(int n, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (n) send_agent(random_agent());
        idle_pct = 0;
        stall_pct = 0;
    endtask

    function automatic agent_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] sp,
                                  logic [15:0] hx, logic [15:0] hy, logic [31:0] fx,
                                  logic [31:0] fy, logic [15:0] dt);
        agent_t a;
        a = '{px, py, sp, hx, hy, fx, fy, dt};
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // coasting, plain and saturating
        send_agent(mk(0, 0, 32'h0001_0000, 16'h4000, 16'h0000, 0, 0, 16'h8000));
        send_agent(mk(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h7fff, 16'h8000,
                      0, 0, 16'hffff));
        send_agent(mk(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'h8000, 16'h7fff,
                      0, 0, 16'hffff));
        // force within and above the limit
        send_agent(mk(32'h0010_0000, 32'hfff0_0000, 32'h0002_0000, 16'h0000, 16'h4000,
                      32'h0000_8000, 32'h0000_4000, 16'h4000));
        send_agent(mk(0, 0, 32'h0003_0000, 16'h2d41, 16'h2d41,
                      32'h7fff_ffff, 32'h8000_0000, 16'hffff));
        send_agent(mk(0, 0, 32'h0003_0000, 16'hc000, 16'h0000,
                      32'h8000_0000, 32'h8000_0000, 16'h1234));
        // velocity large enough to need the pre-shift
        send_agent(mk(0, 0, 32'hffff_ffff, 16'h7fff, 16'h7fff,
                      32'h0000_0001, 32'h0000_0001, 16'hffff));
        send_agent(mk(0, 0, 32'hffff_ffff, 16'h8000, 16'h8000,
                      32'hffff_ffff, 32'h0000_0000, 16'h0001));
        // zero velocity: halted, position and heading kept; then a near-cancelling force
        send_agent(mk(32'h1234_5678, 32'h8765_4321, 0, 16'h4000, 16'h0000,
                      32'h0000_0001, 0, 16'h0000));
        send_agent(mk(32'h0001_0000, 0, 32'h0001_0000, 16'h4000, 16'h0000,
                      32'hffff_0000, 0, 16'hffff));
        // an oversized heading, renormalized from the velocity
        send_agent(mk(0, 0, 32'h0001_0000, 16'h7fff, 16'h0000,
                      32'h0000_0010, 32'h0000_0000, 16'h0001));
        send_agent(mk(0, 0, 32'h0001_0000, 16'h8000, 16'h8000,
                      32'hffff_fff0, 32'h0000_0000, 16'h0001));
        // speed clamp with a big force
        send_agent(mk(0, 0, 32'h00ff_0000, 16'h4000, 16'h0000,
                      32'h0100_0000, 32'h0100_0000, 16'hffff));
        wait_idle();
    endtask

    task automatic test_limits();
        // writes to unused indexes are ignored
        write_reg(REG_UNUSED_A, 32'h0000_0001);
        write_reg(REG_UNUSED_B, 32'hffff_ffff);
        run_random(40, 0, 0);
        set_limits(32'h0000_0000, 32'h0000_0000);
        test_directed();
        run_random(60, 0, 0);
        set_limits(32'hffff_ffff, 32'hffff_ffff);
        test_directed();
        run_random(60, 0, 0);
        set_limits(32'h0000_0001, 32'h8000_0000);
        run_random(40, 0, 0);
        set_limits(FORCE_LIMIT_RESET, SPEED_LIMIT_RESET);
    endtask

    task automatic test_idling();
        run_random(150, 0, 0);
        run_random(150, 74, 0);
        run_random(150, 0, 74);
        set_limits(32'h0100_0000, 32'h0400_0000);
        run_random(150, 26, 26);
        run_random(100, 0, 0);
    endtask

    task automatic test_backpressure();
        hold_left = 400;
        run_random(200, 0, 0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_limits();
        test_idling();
        test_backpressure();
        wait_idle();
        if (!failed)
            $display("agent_motion_integrator_top verification clean");
        else
            $display("agent_motion_integrator_top verification failed");
        $finish;
    end

endmodule
